@@ rtl/pspf_pkg.sv @@
// ----------------------------------------------------------------------------
// pspf_pkg
// Shared constants and types for the PLL serial programming frame core.
// ----------------------------------------------------------------------------
package pspf_pkg;

  // default sizes of the programmable and reference words and the digit count
  localparam int PROG_BITS_DEF   = 17;
  localparam int REF_BITS_DEF    = 12;
  localparam int DIGIT_COUNT_DEF = 5;

  // fixed widths of the request fields
  localparam int NUM_DIGIT_FIELDS = 5;
  localparam int DIGIT_W          = 4;
  localparam int REF_IN_W         = 12;

  // option word, bit 0 goes out first
  localparam int               OPTION_LEN  = 11;
  localparam logic [OPTION_LEN-1:0] OPTION_WORD = 11'b100_0001_1000;

  typedef logic [1:0]         unit_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam unit_t UNIT_FM_TX = 2'd0;
  localparam unit_t UNIT_CW_TX = 2'd1;
  localparam unit_t UNIT_FM_RX = 2'd2;
  localparam unit_t UNIT_NONE  = 2'd3;

  localparam logic PULSE_DATA   = 1'b0;
  localparam logic PULSE_STROBE = 1'b1;

endpackage

@@ rtl/pspf_front.sv @@
// ----------------------------------------------------------------------------
// pspf_front
// Takes requests, drops unknown units and turns the decimal divider into
// binary one digit per cycle before handing the word to the queue.
// ----------------------------------------------------------------------------
module pspf_front #(
  parameter int PROG_BITS   = pspf_pkg::PROG_BITS_DEF,
  parameter int REF_BITS    = pspf_pkg::REF_BITS_DEF,
  parameter int DIGIT_COUNT = pspf_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pspf_pkg::unit_t                     unit,
  input  logic [pspf_pkg::REF_IN_W-1:0]       ref_count,
  input  pspf_pkg::digit_t                    prog_digit_0,
  input  pspf_pkg::digit_t                    prog_digit_1,
  input  pspf_pkg::digit_t                    prog_digit_2,
  input  pspf_pkg::digit_t                    prog_digit_3,
  input  pspf_pkg::digit_t                    prog_digit_4,
  output logic                                q_push,
  input  logic                                q_full,
  output logic [2+REF_BITS+PROG_BITS-1:0]     q_data
);
  import pspf_pkg::*;

  localparam int CW      = $clog2(DIGIT_COUNT + 1);
  localparam int REF_EXT = REF_BITS + REF_IN_W;

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [PROG_BITS-1:0] acc;
  digit_t               dig [NUM_DIGIT_FIELDS];
  unit_t                unit_q;
  logic [REF_BITS-1:0]  ref_q;
  logic [REF_EXT-1:0]   ref_ext;
  logic                 accept;
  logic                 converting;

  assign ref_ext    = REF_EXT'(ref_count);
  assign in_stall   = busy;
  assign accept     = in_valid && !busy;
  assign converting = busy && (cnt != CW'(DIGIT_COUNT));
  assign q_push     = busy && (cnt == CW'(DIGIT_COUNT)) && !q_full;
  assign q_data     = {unit_q, ref_q, acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= (unit != UNIT_NONE);
      cnt  <= '0;
    end else if (converting) begin
      cnt <= cnt + CW'(1);
    end else if (q_push) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unit_q <= unit;
      ref_q  <= ref_ext[REF_BITS-1:0];
      acc    <= '0;
      dig[0] <= prog_digit_0;
      dig[1] <= prog_digit_1;
      dig[2] <= prog_digit_2;
      dig[3] <= prog_digit_3;
      dig[4] <= prog_digit_4;
    end else if (converting) begin
      // acc * 10 + digit, kept modulo the word width
      acc <= (acc << 3) + (acc << 1) + PROG_BITS'(dig[0]);
      for (int i = 0; i < NUM_DIGIT_FIELDS - 1; i++) begin
        dig[i] <= dig[i+1];
      end
      dig[NUM_DIGIT_FIELDS-1] <= '0;
    end
  end

endmodule

@@ rtl/pspf_queue.sv @@
// ----------------------------------------------------------------------------
// pspf_queue
// Two-entry queue between the converter and the serializer.
// ----------------------------------------------------------------------------
module pspf_queue #(
  parameter int WIDTH = 2 + pspf_pkg::REF_BITS_DEF + pspf_pkg::PROG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);
  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'(DEPTH));
  assign valid   = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wr_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH)) else $error("queue count overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");

endmodule

@@ rtl/pspf_back.sv @@
// ----------------------------------------------------------------------------
// pspf_back
// Serializer: walks each frame word by word, holding while the output stalls, through
// option, reference and programmable words, each with group code and strobe, into an output register.
// ----------------------------------------------------------------------------
module pspf_back #(
  parameter int PROG_BITS = pspf_pkg::PROG_BITS_DEF,
  parameter int REF_BITS  = pspf_pkg::REF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  logic [2+REF_BITS+PROG_BITS-1:0] q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pspf_pkg::unit_t                 unit_sel,
  output logic                            pulse_kind,
  output logic                            data_bit,
  output logic                            last
);
  import pspf_pkg::*;

  localparam int OPT_END = OPTION_LEN;
  localparam int REF_LO  = OPT_END + 3;
  localparam int REF_HI  = REF_LO + REF_BITS;
  localparam int PROG_LO = REF_HI + 3;
  localparam int PROG_HI = PROG_LO + PROG_BITS;
  localparam int TOTAL   = PROG_HI + 3;
  localparam int PW      = $clog2(TOTAL);

  logic                  active;
  logic [PW-1:0]         pos;
  unit_t                 unit_r;
  logic [OPTION_LEN-1:0] opt_sr;
  logic [REF_BITS-1:0]   ref_sr;
  logic [PROG_BITS-1:0]  prog_sr;
  logic                  advance;
  logic                  emit;
  logic                  at_end;
  logic                  take;
  logic                  in_opt;
  logic                  in_ref;
  logic                  in_prog;
  logic                  ev_kind;
  logic                  ev_bit;
  logic                  ev_last;

  assign advance = !out_valid || !out_stall;
  assign emit    = active && advance;
  assign at_end  = (pos == PW'(TOTAL - 1));
  assign take    = q_valid && (!active || (emit && at_end));
  assign q_pop   = take;

  assign in_opt  = (pos < PW'(OPT_END));
  assign in_ref  = (pos >= PW'(REF_LO)) && (pos < PW'(REF_HI));
  assign in_prog = (pos >= PW'(PROG_LO)) && (pos < PW'(PROG_HI));

  always_comb begin
    ev_kind = PULSE_DATA;
    ev_bit  = 1'b0;
    ev_last = 1'b0;
    if (in_opt) begin
      ev_bit = opt_sr[0];
    end else if (in_ref) begin
      ev_bit = ref_sr[0];
    end else if (in_prog) begin
      ev_bit = prog_sr[0];
    end else if (pos == PW'(REF_HI) || pos == PW'(REF_HI + 1)) begin
      ev_bit = 1'b1;   // group code 11
    end else if (pos == PW'(PROG_HI)) begin
      ev_bit = 1'b1;   // group code 10, first bit
    end else if (pos == PW'(OPT_END + 2) || pos == PW'(REF_HI + 2)) begin
      ev_kind = PULSE_STROBE;
    end else if (at_end) begin
      ev_kind = PULSE_STROBE;
      ev_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        active <= 1'b1;
        pos    <= '0;
      end else if (emit) begin
        if (at_end) active <= 1'b0;
        pos <= pos + PW'(1);
      end
      if (advance) out_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      {unit_r, ref_sr, prog_sr} <= q_data;
      opt_sr <= OPTION_WORD;
    end else if (emit) begin
      if (in_opt)  opt_sr  <= opt_sr >> 1;
      if (in_ref)  ref_sr  <= ref_sr >> 1;
      if (in_prog) prog_sr <= prog_sr >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unit_sel   <= unit_r;
      pulse_kind <= ev_kind;
      data_bit   <= ev_bit;
      last       <= ev_last;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    active |-> pos <= PW'(TOTAL - 1)) else $error("frame position out of range");

  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (pulse_kind == PULSE_STROBE && data_bit == 1'b0))
    else $error("last word is not a strobe");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

@@ rtl/pll_serial_programming_frame_core.sv @@
// ----------------------------------------------------------------------------
// pll_serial_programming_frame_core
// Path: an accepted request passes through digit conversion, the queue and
//   the serializer register before its first word reaches the output.
// Frame: 20 + REF_BITS + PROG_BITS words (49 by default), emitted by the
//   serializer one word per cycle while out_stall is low.
// Reset: synchronous rst empties converter, queue and serializer at once.
// ----------------------------------------------------------------------------
module pll_serial_programming_frame_core #(
  parameter int PROG_BITS   = pspf_pkg::PROG_BITS_DEF,
  parameter int REF_BITS    = pspf_pkg::REF_BITS_DEF,
  parameter int DIGIT_COUNT = pspf_pkg::DIGIT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pspf_pkg::unit_t               unit,
  input  logic [pspf_pkg::REF_IN_W-1:0] ref_count,
  input  pspf_pkg::digit_t              prog_digit_0,
  input  pspf_pkg::digit_t              prog_digit_1,
  input  pspf_pkg::digit_t              prog_digit_2,
  input  pspf_pkg::digit_t              prog_digit_3,
  input  pspf_pkg::digit_t              prog_digit_4,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pspf_pkg::unit_t               unit_sel,
  output logic                          pulse_kind,
  output logic                          data_bit,
  output logic                          last
);
  import pspf_pkg::*;

  localparam int QW = 2 + REF_BITS + PROG_BITS;

  logic          push;
  logic          full;
  logic [QW-1:0] wr_data;
  logic          pop;
  logic          qv;
  logic [QW-1:0] rd_data;

  pspf_front #(
    .PROG_BITS  (PROG_BITS),
    .REF_BITS   (REF_BITS),
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .unit        (unit),
    .ref_count   (ref_count),
    .prog_digit_0(prog_digit_0),
    .prog_digit_1(prog_digit_1),
    .prog_digit_2(prog_digit_2),
    .prog_digit_3(prog_digit_3),
    .prog_digit_4(prog_digit_4),
    .q_push      (push),
    .q_full      (full),
    .q_data      (wr_data)
  );

  pspf_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(wr_data),
    .full   (full),
    .pop    (pop),
    .valid  (qv),
    .rd_data(rd_data)
  );

  pspf_back #(
    .PROG_BITS(PROG_BITS),
    .REF_BITS (REF_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qv),
    .q_data    (rd_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .unit_sel  (unit_sel),
    .pulse_kind(pulse_kind),
    .data_bit  (data_bit),
    .last      (last)
  );

endmodule
